// ----- hdl/smt_pkg.sv -----
// Shared types and constants for the sorted multiset table.
package smt_pkg;

    localparam int SMT_CAPACITY  = 16;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 32;
    localparam int S_TUSER_W     = 1;
    localparam int M_TDATA_W     = 72;
    localparam int M_TUSER_W     = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // request broadcast to every cell of the row
    typedef struct packed {
        cmd_t                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } cell_op_t;

endpackage

// ----- hdl/smt_cell.sv -----
// One table slot: compares its entry with the request and shifts with its neighbors.
module smt_cell
    import smt_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en,
    input  cell_op_t                   op,
    input  logic                       occupied,
    input  logic                       left_keep,
    input  logic signed [VALUE_W-1:0]  left_data,
    input  logic signed [VALUE_W-1:0]  right_data,
    output logic                       keep,
    output logic                       hit,
    output logic signed [VALUE_W-1:0]  data
);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    // insert keeps entries <= value, remove keeps entries < value
    always_comb begin
        if (op.cmd == CMD_INSERT) begin
            keep = occupied && (data_reg <= op.value);
        end else begin
            keep = occupied && (data_reg < op.value);
        end
    end

    // first equal entry: left neighbor is smaller (or this is the head)
    assign hit = (op.cmd == CMD_REMOVE) && occupied && (data_reg == op.value) && left_keep;

    always_comb begin
        if (op.cmd == CMD_INSERT) begin
            data_next = left_keep ? op.value : left_data;
        end else begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !keep) begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// ----- hdl/smt_summary.sv -----
// Result stage: picks head and tail of the row and holds the outgoing result.
module smt_summary
    import smt_pkg::*;
#(
    parameter int CAPACITY = SMT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pend_valid,
    input  status_t                    pend_status,
    input  logic [CNT_W-1:0]           count,
    input  logic signed [VALUE_W-1:0]  cell_data [CAPACITY],
    output logic                       pend_take,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // entry_count[4:0], smallest, largest, is_empty, pad
    output logic [M_TUSER_W-1:0]       m_tuser    // status[1:0]
);

    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg;
    logic [M_TDATA_W-1:0]      m_tdata_next;
    logic [M_TUSER_W-1:0]      m_tuser_reg;
    logic [M_TUSER_W-1:0]      m_tuser_next;
    logic signed [VALUE_W-1:0] smallest;
    logic signed [VALUE_W-1:0] largest;
    logic                      is_empty;

    assign pend_take = pend_valid && (!m_tvalid_reg || m_tready);
    assign is_empty  = (count == '0);
    assign smallest  = is_empty ? '0 : cell_data[0];

    // tail is the cell at count-1; one-hot AND-OR select
    always_comb begin
        largest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (count == CNT_W'(i + 1)) begin
                largest = largest | cell_data[i];
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (pend_take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, is_empty, largest, smallest, ENTRY_COUNT_W'(count)};
            m_tuser_next  = pend_status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hdl/sorted_multiset_table_top.sv -----
// Sorted multiset table: a row of compare-and-shift cells plus a result stage.
// An accepted request is registered in the pending stage, then in the result output register.
// Throughput: one request per cycle unless m_tready stalls the result stage; every cell
// decides its move in parallel from its own compare and its left neighbor's keep flag.
// Reset (aresetn low, synchronous): entry count and handshake state cleared, no clearing
// pass; cell contents are left as they are and only cells below the count are ever used.
module sorted_multiset_table_top
    import smt_pkg::*;
#(
    parameter int CAPACITY = SMT_CAPACITY
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // value[31:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // cmd[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // entry_count[4:0], smallest, largest, is_empty, pad
    output logic [M_TUSER_W-1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      accept;
    logic                      pend_take;
    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    status_t                   pend_status_reg;
    status_t                   pend_status_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      full;
    logic                      found;
    cmd_t                      cmd;
    cell_op_t                  op;
    logic                      cell_en;
    logic [CAPACITY-1:0]       keep_vec;
    logic [CAPACITY-1:0]       hit_vec;
    logic signed [VALUE_W-1:0] cell_data [CAPACITY];

    assign cmd      = cmd_t'(s_tuser[0]);
    assign s_tready = !pend_valid_reg || pend_take;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = |hit_vec;

    always_comb begin
        op.cmd   = cmd;
        op.value = s_tdata[VALUE_W-1:0];
    end

    assign cell_en = accept && ((cmd == CMD_INSERT) ? !full : found);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      left_keep;
        logic signed [VALUE_W-1:0] left_data;
        logic signed [VALUE_W-1:0] right_data;

        if (i == 0) begin : g_head
            assign left_keep = 1'b1;
            assign left_data = op.value;
        end else begin : g_mid
            assign left_keep = keep_vec[i-1];
            assign left_data = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_data = op.value;
        end else begin : g_body
            assign right_data = cell_data[i+1];
        end

        smt_cell u_cell (
            .aclk       (aclk),
            .en         (cell_en),
            .op         (op),
            .occupied   (count_reg > CNT_W'(i)),
            .left_keep  (left_keep),
            .left_data  (left_data),
            .right_data (right_data),
            .keep       (keep_vec[i]),
            .hit        (hit_vec[i]),
            .data       (cell_data[i])
        );
    end

    always_comb begin
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_valid_next  = pend_valid_reg;
        if (pend_take) begin
            pend_valid_next = 1'b0;
        end
        if (accept) begin
            pend_valid_next = 1'b1;
            if (cmd == CMD_INSERT) begin
                if (full) begin
                    pend_status_next = ST_FULL;
                end else begin
                    pend_status_next = ST_DONE;
                    count_next       = count_reg + 1'b1;
                end
            end else begin
                if (found) begin
                    pend_status_next = ST_DONE;
                    count_next       = count_reg - 1'b1;
                end else begin
                    pend_status_next = ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
        pend_status_reg <= pend_status_next;
    end

    smt_summary #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_summary (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pend_valid  (pend_valid_reg),
        .pend_status (pend_status_reg),
        .count       (count_reg),
        .cell_data   (cell_data),
        .pend_take   (pend_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_INSERT && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the table");

    a_miss_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == CMD_REMOVE && !found) |=> $stable(count_reg))
        else $error("missed remove changed the count");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("more than one cell claims the removed entry");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && pend_status_reg == ST_FULL) |-> full)
        else $error("full status with room left");

endmodule
